FILE: sv/tbdh_pkg.sv
// shared types and constants for the two-button debounce and hold detector
// no dependencies; imported by every module of the block
package tbdh_pkg;

   // configuration register indexes (byte address / 4)
   localparam int unsigned REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ARM_HIGH    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SCAN_PERIOD = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RESET_HOLD  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MASTER_HOLD = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MIN_UPTIME  = 3'd5;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // register reset values
   localparam logic [15:0] DEBOUNCE_RST    = 16'd60;
   localparam logic [15:0] ARM_HIGH_RST    = 16'd500;
   localparam logic [9:0]  SCAN_PERIOD_RST = 10'd20;
   localparam logic [15:0] RESET_HOLD_RST  = 16'd5000;
   localparam logic [15:0] MASTER_HOLD_RST = 16'd10000;
   localparam logic [7:0]  MIN_UPTIME_RST  = 8'd5;

   // action codes
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_MASTER  = 2'd1;
   localparam logic [1:0] ACT_CONFIG  = 2'd2;
   localparam logic [1:0] ACT_REFUSED = 2'd3;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        reset_raw_low;
      logic        boot_raw_low;
      logic [31:0] uptime_s;
      logic        charging_active;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic       reset_stable_low;
      logic       boot_debounced;
      logic       armed_flag;
   } rsp_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] arm_high_ms;
      logic [9:0]  scan_period_ms;
      logic [15:0] reset_hold_ms;
      logic [15:0] master_hold_ms;
      logic [7:0]  min_uptime_s;
   } cfg_type;

   // control flags of the detector, watched by the top level
   typedef struct packed {
      logic halted;
      logic waiting_release;
      logic combo_held;
      logic single_held;
      logic armed;
   } sts_type;

endpackage

FILE: sv/tbdh_csr.sv
// configuration registers behind the apb-style port
// depends on tbdh_pkg for register indexes, reset values and cfg_type
module tbdh_csr
   import tbdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DEBOUNCE:    cfg_in.debounce_ms    = csr_pwdata[15:0];
            REG_ARM_HIGH:    cfg_in.arm_high_ms    = csr_pwdata[15:0];
            REG_SCAN_PERIOD: cfg_in.scan_period_ms = csr_pwdata[9:0];
            REG_RESET_HOLD:  cfg_in.reset_hold_ms  = csr_pwdata[15:0];
            REG_MASTER_HOLD: cfg_in.master_hold_ms = csr_pwdata[15:0];
            REG_MIN_UPTIME:  cfg_in.min_uptime_s   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms    <= DEBOUNCE_RST;
         cfg_ff.arm_high_ms    <= ARM_HIGH_RST;
         cfg_ff.scan_period_ms <= SCAN_PERIOD_RST;
         cfg_ff.reset_hold_ms  <= RESET_HOLD_RST;
         cfg_ff.master_hold_ms <= MASTER_HOLD_RST;
         cfg_ff.min_uptime_s   <= MIN_UPTIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DEBOUNCE:    csr_prdata = {16'd0, cfg_ff.debounce_ms};
         REG_ARM_HIGH:    csr_prdata = {16'd0, cfg_ff.arm_high_ms};
         REG_SCAN_PERIOD: csr_prdata = {22'd0, cfg_ff.scan_period_ms};
         REG_RESET_HOLD:  csr_prdata = {16'd0, cfg_ff.reset_hold_ms};
         REG_MASTER_HOLD: csr_prdata = {16'd0, cfg_ff.master_hold_ms};
         REG_MIN_UPTIME:  csr_prdata = {24'd0, cfg_ff.min_uptime_s};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/tbdh_logic.sv
// debounce, arming and hold detection state with its next-state logic
// depends on tbdh_pkg for req_type, rsp_type, cfg_type and action codes
module tbdh_logic
   import tbdh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    step,
   input  req_type item,
   output rsp_type result,
   output sts_type sts
);

   logic        reset_raw_last_ff, reset_raw_last_in;
   logic        boot_raw_last_ff, boot_raw_last_in;
   logic [31:0] reset_change_time_ff, reset_change_time_in;
   logic [31:0] boot_change_time_ff, boot_change_time_in;
   logic        reset_stable_ff, reset_stable_in;
   logic        boot_stable_ff, boot_stable_in;
   logic [15:0] released_time_ff, released_time_in;
   logic        combo_held_ff, combo_held_in;
   logic [31:0] combo_time_ff, combo_time_in;
   logic        single_held_ff, single_held_in;
   logic        armed_ff, armed_in;
   logic [31:0] single_time_ff, single_time_in;
   logic        waiting_release_ff, waiting_release_in;
   logic        halted_ff, halted_in;

   logic [1:0]  action;
   logic        up_ok;
   logic [31:0] reset_age, boot_age;
   logic [16:0] released_sum;
   logic [32:0] combo_sum, single_sum;
   logic [31:0] combo_next, single_next;

   assign up_ok     = item.uptime_s >= {24'd0, cfg.min_uptime_s};
   assign reset_age = item.now_ms - reset_change_time_ff;
   assign boot_age  = item.now_ms - boot_change_time_ff;
   assign combo_sum  = {1'b0, combo_time_ff} + {23'd0, cfg.scan_period_ms};
   assign single_sum = {1'b0, single_time_ff} + {23'd0, cfg.scan_period_ms};

   always_comb begin
      reset_raw_last_in    = reset_raw_last_ff;
      boot_raw_last_in     = boot_raw_last_ff;
      reset_change_time_in = reset_change_time_ff;
      boot_change_time_in  = boot_change_time_ff;
      reset_stable_in      = reset_stable_ff;
      boot_stable_in       = boot_stable_ff;
      released_time_in     = released_time_ff;
      combo_held_in        = combo_held_ff;
      combo_time_in        = combo_time_ff;
      single_held_in       = single_held_ff;
      armed_in             = armed_ff;
      single_time_in       = single_time_ff;
      waiting_release_in   = waiting_release_ff;
      halted_in            = halted_ff;
      action               = ACT_NONE;
      released_sum         = '0;
      combo_next           = '0;
      single_next          = '0;

      if (halted_ff) begin
      end else if (waiting_release_ff) begin
         if (!item.reset_raw_low && !item.boot_raw_low) begin
            waiting_release_in = 1'b0;
         end
      end else begin
         // per-button debounce on timestamp age
         if (item.reset_raw_low != reset_raw_last_ff) begin
            reset_raw_last_in    = item.reset_raw_low;
            reset_change_time_in = item.now_ms;
         end else if (reset_age >= {16'd0, cfg.debounce_ms}) begin
            reset_stable_in = item.reset_raw_low;
         end
         if (item.boot_raw_low != boot_raw_last_ff) begin
            boot_raw_last_in    = item.boot_raw_low;
            boot_change_time_in = item.now_ms;
         end else if (boot_age >= {16'd0, cfg.debounce_ms}) begin
            boot_stable_in = item.boot_raw_low;
         end

         // released time, clamped at the arm threshold
         if (!reset_stable_in) begin
            if (released_time_ff < cfg.arm_high_ms) begin
               released_sum = {1'b0, released_time_ff} + {7'd0, cfg.scan_period_ms};
               released_time_in = (released_sum > {1'b0, cfg.arm_high_ms}) ?
                                  cfg.arm_high_ms : released_sum[15:0];
            end
         end else begin
            released_time_in = '0;
         end

         if (reset_stable_in && boot_stable_in) begin
            combo_next = !combo_held_ff ? 32'd0 :
                         (combo_sum[32] ? '1 : combo_sum[31:0]);
            combo_held_in  = 1'b1;
            combo_time_in  = combo_next;
            single_held_in = 1'b0;
            armed_in       = 1'b0;
            single_time_in = '0;
            if (combo_next >= {16'd0, cfg.master_hold_ms} && up_ok) begin
               action             = ACT_MASTER;
               combo_held_in      = 1'b0;
               combo_time_in      = '0;
               waiting_release_in = 1'b1;
            end
         end else begin
            combo_held_in = 1'b0;
            combo_time_in = '0;
            if (!reset_stable_in) begin
               armed_in       = released_time_in >= cfg.arm_high_ms;
               single_held_in = 1'b0;
               single_time_in = '0;
            end else if (armed_ff) begin
               if (!single_held_ff) begin
                  single_held_in = 1'b1;
                  single_time_in = '0;
               end else begin
                  single_next    = single_sum[32] ? '1 : single_sum[31:0];
                  single_time_in = single_next;
                  if (single_next >= {16'd0, cfg.reset_hold_ms} && up_ok) begin
                     if (item.charging_active) begin
                        action         = ACT_REFUSED;
                        single_held_in = 1'b0;
                        armed_in       = 1'b0;
                        single_time_in = '0;
                     end else begin
                        action    = ACT_CONFIG;
                        halted_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_raw_last_ff    <= 1'b0;
         boot_raw_last_ff     <= 1'b0;
         reset_change_time_ff <= '0;
         boot_change_time_ff  <= '0;
         reset_stable_ff      <= 1'b0;
         boot_stable_ff       <= 1'b0;
         released_time_ff     <= '0;
         combo_held_ff        <= 1'b0;
         combo_time_ff        <= '0;
         single_held_ff       <= 1'b0;
         armed_ff             <= 1'b0;
         single_time_ff       <= '0;
         waiting_release_ff   <= 1'b0;
         halted_ff            <= 1'b0;
      end else if (step) begin
         reset_raw_last_ff    <= reset_raw_last_in;
         boot_raw_last_ff     <= boot_raw_last_in;
         reset_change_time_ff <= reset_change_time_in;
         boot_change_time_ff  <= boot_change_time_in;
         reset_stable_ff      <= reset_stable_in;
         boot_stable_ff       <= boot_stable_in;
         released_time_ff     <= released_time_in;
         combo_held_ff        <= combo_held_in;
         combo_time_ff        <= combo_time_in;
         single_held_ff       <= single_held_in;
         armed_ff             <= armed_in;
         single_time_ff       <= single_time_in;
         waiting_release_ff   <= waiting_release_in;
         halted_ff            <= halted_in;
      end
   end

   assign result.action           = action;
   assign result.reset_stable_low = reset_stable_in;
   assign result.boot_debounced   = boot_stable_in;
   assign result.armed_flag       = armed_in;

   assign sts.halted          = halted_ff;
   assign sts.waiting_release = waiting_release_ff;
   assign sts.combo_held      = combo_held_ff;
   assign sts.single_held     = single_held_ff;
   assign sts.armed           = armed_ff;

endmodule

FILE: sv/two_button_debounce_hold_detector_unit.sv
// two-button debounce and hold detector, one scan tick per beat
// path: each req beat passes the input register and then the result register
// throughput: one tick per cycle when rsp_ready does not stall the result register;
// the detector state updates as a tick moves into the result register, so the next
// tick sees the updated state
// reset: synchronous, active high; clears the detector state and pipeline, and
// loads the register defaults
module two_button_debounce_hold_detector_unit
   import tbdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   sts_type sts;
   rsp_type result;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    advance;

   tbdh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tbdh_logic u_logic (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_data_ff),
      .result (result),
      .sts    (sts)
   );

   // tick moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // once halted only reset brings the detector back
   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      sts.halted |=> sts.halted)
      else $error("halted flag dropped without reset");

   // halt and release wait are never pending together
   a_halt_wait_excl : assert property (@(posedge clock) disable iff (reset)
      !(sts.halted && sts.waiting_release))
      else $error("halted while waiting for release");

   // a two-button hold clears the single-button arming
   a_combo_disarms : assert property (@(posedge clock) disable iff (reset)
      sts.combo_held |-> (!sts.armed && !sts.single_held))
      else $error("armed or single hold during combo hold");

   // a master reset beat leaves the block waiting for release
   a_master_waits : assert property (@(posedge clock) disable iff (reset)
      (advance && result.action == ACT_MASTER) |=> sts.waiting_release)
      else $error("master reset without release wait");

endmodule

FILE: verif/two_button_debounce_hold_detector_unit_tb.sv
// self-checking testbench for the two-button debounce and hold detector
// depends on tbdh_pkg and two_button_debounce_hold_detector_unit; predicts each result
// beat from its own copy of the detector state and checks it field by field
module two_button_debounce_hold_detector_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tbdh_pkg::*;

   localparam int WATCHDOG_CYCLES = 3000;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int MAX_PRINTED_ERR = 20;

   typedef struct packed {
      logic        r_last;
      logic        b_last;
      logic [31:0] r_chg;
      logic [31:0] b_chg;
      logic        r_stab;
      logic        b_stab;
      logic [15:0] rel_time;
      logic        combo_on;
      logic [31:0] combo_ms;
      logic        single_on;
      logic        armed;
      logic [31:0] single_ms;
      logic        wait_rel;
      logic        halted;
   } det_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   two_button_debounce_hold_detector_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   cfg_type       cfg;
   det_state_type model_st;      // follows accepted beats
   det_state_type plan_st;       // follows generated ticks, steers stimulus
   logic [31:0]   plan_now;
   req_type       tick_q[$];
   rsp_type       status_q[$];
   int            n_queued = 0;
   int            n_checked = 0;
   int            n_err = 0;
   int            n_act[4] = '{0, 0, 0, 0};
   int            n_settings = 0;
   logic          req_took = 1'b0;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [9:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {23'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic rsp_type scan_detector(inout det_state_type s, input cfg_type c,
                                              input req_type q);
      rsp_type     o;
      logic        up_ok;
      logic [31:0] dt;
      logic [16:0] rel_sum;
      logic [1:0]  act;
      act = ACT_NONE;
      if (s.halted) begin
         // frozen until reset
      end else if (s.wait_rel) begin
         if (!q.reset_raw_low && !q.boot_raw_low)
            s.wait_rel = 1'b0;
      end else begin
         up_ok = q.uptime_s >= {24'd0, c.min_uptime_s};
         dt = q.now_ms - s.r_chg;
         if (q.reset_raw_low != s.r_last) begin
            s.r_last = q.reset_raw_low;
            s.r_chg = q.now_ms;
         end else if (dt >= {16'd0, c.debounce_ms}) begin
            s.r_stab = q.reset_raw_low;
         end
         dt = q.now_ms - s.b_chg;
         if (q.boot_raw_low != s.b_last) begin
            s.b_last = q.boot_raw_low;
            s.b_chg = q.now_ms;
         end else if (dt >= {16'd0, c.debounce_ms}) begin
            s.b_stab = q.boot_raw_low;
         end
         if (!s.r_stab) begin
            if (s.rel_time < c.arm_high_ms) begin
               rel_sum = {1'b0, s.rel_time} + {7'd0, c.scan_period_ms};
               s.rel_time = (rel_sum > {1'b0, c.arm_high_ms}) ? c.arm_high_ms : rel_sum[15:0];
            end
         end else begin
            s.rel_time = '0;
         end
         if (s.r_stab && s.b_stab) begin
            if (!s.combo_on) begin
               s.combo_on = 1'b1;
               s.combo_ms = '0;
            end else begin
               s.combo_ms = sat_add(s.combo_ms, c.scan_period_ms);
            end
            s.single_on = 1'b0;
            s.armed = 1'b0;
            s.single_ms = '0;
            if (s.combo_ms >= {16'd0, c.master_hold_ms} && up_ok) begin
               act = ACT_MASTER;
               s.combo_on = 1'b0;
               s.combo_ms = '0;
               s.wait_rel = 1'b1;
            end
         end else begin
            s.combo_on = 1'b0;
            s.combo_ms = '0;
            if (!s.r_stab) begin
               s.armed = s.rel_time >= c.arm_high_ms;
               s.single_on = 1'b0;
               s.single_ms = '0;
            end else if (s.armed) begin
               if (!s.single_on) begin
                  s.single_on = 1'b1;
                  s.single_ms = '0;
               end else begin
                  s.single_ms = sat_add(s.single_ms, c.scan_period_ms);
                  if (s.single_ms >= {16'd0, c.reset_hold_ms} && up_ok) begin
                     if (q.charging_active) begin
                        act = ACT_REFUSED;
                        s.single_on = 1'b0;
                        s.armed = 1'b0;
                        s.single_ms = '0;
                     end else begin
                        act = ACT_CONFIG;
                        s.halted = 1'b1;
                     end
                  end
               end
            end
         end
      end
      o.action = act;
      o.reset_stable_low = s.r_stab;
      o.boot_debounced = s.b_stab;
      o.armed_flag = s.armed;
      return o;
   endfunction

   task automatic report_err(input string msg);
      n_err++;
      if (n_err <= MAX_PRINTED_ERR)
         $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // ---------------- stimulus helpers ----------------

   function automatic logic [31:0] pick_step();
      int unsigned d;
      d = cfg.debounce_ms;
      case ($urandom_range(0, 19))
         0: return $urandom;
         1: return 32'd0;
         default: return $urandom_range(0, 2 * (d / 3) + 2);
      endcase
   endfunction

   function automatic logic [31:0] pick_uptime();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, cfg.min_uptime_s);
         1: return $urandom;
         default: return cfg.min_uptime_s + $urandom_range(0, 100000);
      endcase
   endfunction

   // scan ticks needed to reach a hold threshold, capped
   function automatic int unsigned ticks_for(input int unsigned thr);
      int unsigned t;
      if (cfg.scan_period_ms == 0)
         return (thr == 0) ? 1 : 80;
      t = thr / cfg.scan_period_ms + 5;
      return (t > 80) ? 80 : t;
   endfunction

   // a config reset halts the block for good, so it is turned into a refusal
   // unless the halt is wanted
   task automatic queue_tick(input req_type q, input bit halt_ok);
      det_state_type trial;
      rsp_type       r;
      trial = plan_st;
      r = scan_detector(trial, cfg, q);
      if (r.action == ACT_CONFIG && !halt_ok) begin
         q.charging_active = 1'b1;
         trial = plan_st;
         r = scan_detector(trial, cfg, q);
      end
      plan_st = trial;
      tick_q.push_back(q);
      n_queued++;
   endtask

   task automatic fixed_tick(input logic [31:0] now, input logic r, input logic b,
                             input logic [31:0] up, input logic chg);
      req_type q;
      q.now_ms = now;
      q.reset_raw_low = r;
      q.boot_raw_low = b;
      q.uptime_s = up;
      q.charging_active = chg;
      queue_tick(q, 1'b0);
   endtask

   task automatic random_tick(input logic r, input logic b);
      req_type q;
      plan_now = plan_now + pick_step();
      q.now_ms = plan_now;
      q.reset_raw_low = r;
      q.boot_raw_low = b;
      q.uptime_s = pick_uptime();
      q.charging_active = $urandom_range(0, 1) != 0;
      queue_tick(q, 1'b0);
   endtask

   // either random ticks, or a released lead-in, optional bounce, then a press of one or both buttons
   task automatic run_sequence();
      int unsigned kind;
      int unsigned n;
      int unsigned hold;
      logic        r_on;
      logic        b_on;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         n = $urandom_range(4, 12);
         repeat (n)
            random_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      end else begin
         r_on = kind <= 8;
         b_on = kind >= 6;
         n = $urandom_range(1, ticks_for(cfg.arm_high_ms) + 4);
         repeat (n) random_tick(1'b0, 1'b0);
         if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n)
               random_tick(r_on && ($urandom_range(0, 1) != 0),
                           b_on && ($urandom_range(0, 1) != 0));
         end
         hold = ticks_for((r_on && b_on) ? cfg.master_hold_ms : cfg.reset_hold_ms) + 2;
         if ($urandom_range(0, 4) < 2)
            hold = $urandom_range(1, hold);
         else
            hold = hold + $urandom_range(0, 6);
         repeat (hold) random_tick(r_on, b_on);
      end
   endtask

   task automatic csr_write(input int unsigned idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx * 4);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_DEBOUNCE:    cfg.debounce_ms = value[15:0];
         REG_ARM_HIGH:    cfg.arm_high_ms = value[15:0];
         REG_SCAN_PERIOD: cfg.scan_period_ms = value[9:0];
         REG_RESET_HOLD:  cfg.reset_hold_ms = value[15:0];
         REG_MASTER_HOLD: cfg.master_hold_ms = value[15:0];
         REG_MIN_UPTIME:  cfg.min_uptime_s = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int unsigned d, input int unsigned a, input int unsigned s,
                             input int unsigned rh, input int unsigned mh,
                             input int unsigned mu);
      csr_write(REG_DEBOUNCE, d);
      csr_write(REG_ARM_HIGH, a);
      csr_write(REG_SCAN_PERIOD, s);
      csr_write(REG_RESET_HOLD, rh);
      csr_write(REG_MASTER_HOLD, mh);
      csr_write(REG_MIN_UPTIME, mu);
      n_settings++;
   endtask

   // every tick gives one result; wait for all, then let the pipeline settle
   task automatic wait_drain();
      while (n_checked != n_queued) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned d, input int unsigned a, input int unsigned s,
                            input int unsigned rh, input int unsigned mh,
                            input int unsigned mu, input int budget);
      int start;
      set_config(d, a, s, rh, mh, mu);
      start = n_queued;
      while (n_queued - start < budget) run_sequence();
      wait_drain();
   endtask

   // ---------------- driver: bursts with random gaps ----------------

   int burst_left = 5;
   int gap_left = 0;

   always @(negedge clock) begin
      logic    nv;
      req_type nd;
      nv = 1'b0;
      nd = req_data;
      if (reset) begin
         nv = 1'b0;
      end else if (req_valid && !req_took) begin
         nv = 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
      end else if (tick_q.size() > 0) begin
         nd = tick_q.pop_front();
         nv = 1'b1;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
      req_valid <= nv;
      req_data <= nd;
   end

   // ---------------- receiver: stall pattern plus one long hold-off ----------------

   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_mode = 0;
   int mode_left = 0;
   int rx_cyc = 0;

   always @(negedge clock) begin
      logic nr;
      rx_cyc++;
      if (hold_left > 0) begin
         nr = 1'b0;
         hold_left--;
      end else if (!hold_done && n_checked >= 400) begin
         // long hold-off so the block backs up into the sender
         nr = 1'b0;
         hold_left = HOLD_OFF_CYCLES - 1;
         hold_done = 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (stall_mode)
            0: nr = 1'b1;
            1: nr = $urandom_range(0, 3) != 0;
            2: nr = $urandom_range(0, 1) != 0;
            default: nr = (rx_cyc % 3) != 0;
         endcase
      end
      rsp_ready <= nr;
   end

   // ---------------- monitor and checker ----------------

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      rsp_type pred;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         // results first so a beat never meets its own prediction
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (status_q.size() == 0) begin
               report_err("result beat with no expected result");
            end else begin
               want = status_q.pop_front();
               if (got.action !== want.action)
                  report_err($sformatf("tick %0d action %0d, predicted %0d",
                                       n_checked, got.action, want.action));
               if (got.reset_stable_low !== want.reset_stable_low)
                  report_err($sformatf("tick %0d reset_stable_low %0b, predicted %0b",
                                       n_checked, got.reset_stable_low,
                                       want.reset_stable_low));
               if (got.boot_debounced !== want.boot_debounced)
                  report_err($sformatf("tick %0d boot_debounced %0b, predicted %0b",
                                       n_checked, got.boot_debounced,
                                       want.boot_debounced));
               if (got.armed_flag !== want.armed_flag)
                  report_err($sformatf("tick %0d armed_flag %0b, predicted %0b",
                                       n_checked, got.armed_flag, want.armed_flag));
               n_act[want.action]++;
               n_checked++;
            end
         end
         if (req_valid && req_ready) begin
            pred = scan_detector(model_st, cfg, req_data);
            status_q.push_back(pred);
         end
         req_took <= req_valid && req_ready;
      end
   end

   // ---------------- watchdog ----------------

   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog: no beat for %0d cycles, %0d of %0d ticks answered",
                  idle_cycles, n_checked, n_queued);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- test sequence ----------------

   initial begin
      int n;
      req_type q;
      cfg.debounce_ms = DEBOUNCE_RST;
      cfg.arm_high_ms = ARM_HIGH_RST;
      cfg.scan_period_ms = SCAN_PERIOD_RST;
      cfg.reset_hold_ms = RESET_HOLD_RST;
      cfg.master_hold_ms = MASTER_HOLD_RST;
      cfg.min_uptime_s = MIN_UPTIME_RST;
      model_st = '0;
      plan_st = '0;
      plan_now = 32'd1000;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a few ticks on the register defaults
      repeat (8) random_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      wait_drain();
      n_settings++;

      // directed: tiny thresholds, field extremes, timestamp wrap, none, master and refused actions
      set_config(0, 0, 1, 1, 2, 1);
      csr_write(6, $urandom);
      csr_write(7, $urandom);
      fixed_tick(32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
      fixed_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1);
      fixed_tick(32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b1);
      fixed_tick(32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000, 1'b1);
      fixed_tick(32'h0000_0002, 1'b1, 1'b0, 32'h0000_0007, 1'b1);
      fixed_tick(32'h0000_0003, 1'b1, 1'b1, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_0004, 1'b1, 1'b1, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_0005, 1'b1, 1'b1, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_0006, 1'b1, 1'b1, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_0007, 1'b1, 1'b0, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_0008, 1'b0, 1'b1, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_0009, 1'b0, 1'b0, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_000A, 1'b0, 1'b0, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_000B, 1'b0, 1'b0, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_000C, 1'b1, 1'b0, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_000D, 1'b1, 1'b0, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_000E, 1'b1, 1'b0, 32'h0000_0007, 1'b0);
      fixed_tick(32'h0000_000F, 1'b1, 1'b0, 32'h0000_0007, 1'b0);
      fixed_tick(32'hAAAA_AAAA, 1'b0, 1'b1, 32'h5555_5555, 1'b1);
      fixed_tick(32'h5555_5555, 1'b0, 1'b1, 32'hAAAA_AAAA, 1'b0);
      wait_drain();

      // random press sequences under a spread of settings, timestamp about to wrap
      plan_now = 32'hFFFF_F000;
      run_phase(60, 500, 20, 400, 600, 5, 225);
      run_phase(0, 0, 1, 0, 0, 0, 225);
      run_phase(65535, 65535, 1023, 65535, 65535, 255, 225);
      run_phase(25, 0, 0, 0, 40, 3, 225);
      run_phase(200, 300, 700, 1400, 2000, 100, 225);
      run_phase(5, 40, 7, 65535, 3, 0, 225);

      // last: hold reset while not charging until the block halts, then poke it
      set_config(30, 100, 50, 200, 300, 1);
      repeat (20) random_tick(1'b0, 1'b0);
      n = 0;
      while (!plan_st.halted && n < 200) begin
         plan_now = plan_now + pick_step();
         q.now_ms = plan_now;
         q.reset_raw_low = 1'b1;
         q.boot_raw_low = 1'b0;
         q.uptime_s = 32'd1000;
         q.charging_active = 1'b0;
         queue_tick(q, 1'b1);
         n++;
      end
      repeat (25) random_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      wait_drain();
      repeat (10) @(posedge clock);

      if (status_q.size() != 0)
         report_err($sformatf("%0d predicted results never arrived", status_q.size()));
      $display("run covered %0d scan ticks over %0d register settings, halt at the end",
               n_checked, n_settings);
      $display("actions seen: none %0d, master %0d, config %0d, refused %0d; %0d mismatches",
               n_act[ACT_NONE], n_act[ACT_MASTER], n_act[ACT_CONFIG], n_act[ACT_REFUSED],
               n_err);
      if (n_err == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
sv/tbdh_pkg.sv
sv/tbdh_csr.sv
sv/tbdh_logic.sv
sv/two_button_debounce_hold_detector_unit.sv
verif/two_button_debounce_hold_detector_unit_tb.sv
